// ----- hdl/pgos_pkg.sv -----
// shared types and constants of the retriggerable one-shot pulse generator
`default_nettype none

package pgos_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONESHOT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRIG  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO    = 3'd4;

  // operation codes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_START    = 3'd1;
  localparam logic [2:0] OP_STOP     = 3'd2;
  localparam logic [2:0] OP_ENABLE   = 3'd3;
  localparam logic [2:0] OP_ACTIVATE = 3'd4;

  localparam logic [15:0] PERIOD_RESET   = 16'd1000;
  localparam logic [15:0] PERIOD_DEFAULT = 16'd1000;
  localparam logic [6:0]  DUTY_RESET     = 7'd50;
  localparam logic [6:0]  FULL_PERCENT   = 7'd100;

  // ceil(2^32 / 100): exact quotient for products below 2^30
  localparam int unsigned RECIP_SHIFT = 32;
  localparam logic [25:0] RECIP_100   = 26'd42949673;

  typedef struct packed {
    logic [2:0] operation;
    logic       enable_value;
  } in_item_t;

  typedef struct packed {
    logic out_level;
    logic out_inverted;
    logic active;
  } out_item_t;

  // settings handed from the register block to the core
  typedef struct packed {
    logic [15:0] period;
    logic [15:0] high_w;
    logic        one_shot;
    logic        retriggerable;
    logic        auto_start;
  } cfg_set_t;

endpackage

`default_nettype wire

// ----- hdl/pgos_cfg.sv -----
// configuration registers and the high-width computation
`default_nettype none

module pgos_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [pgos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pgos_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output pgos_pkg::cfg_set_t                 cfg_set
);

  logic [15:0] period_r, period_nxt;
  logic [6:0]  duty_r, duty_nxt;
  logic        one_shot_r, one_shot_nxt;
  logic        retrig_r, retrig_nxt;
  logic        auto_r, auto_nxt;

  logic [15:0] peff_nxt;
  logic [6:0]  dcl_nxt;
  logic [22:0] prod_r, prod_nxt;
  logic [15:0] peff_r;
  logic [48:0] quot_full;
  logic [15:0] high_w_r, high_w_nxt;

  always_comb begin
    period_nxt   = period_r;
    duty_nxt     = duty_r;
    one_shot_nxt = one_shot_r;
    retrig_nxt   = retrig_r;
    auto_nxt     = auto_r;
    if (!rst_n) begin
      period_nxt   = pgos_pkg::PERIOD_RESET;
      duty_nxt     = pgos_pkg::DUTY_RESET;
      one_shot_nxt = 1'b1;
      retrig_nxt   = 1'b0;
      auto_nxt     = 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pgos_pkg::CFG_PERIOD:  period_nxt   = cfg_wdata[15:0];
        pgos_pkg::CFG_DUTY:    duty_nxt     = cfg_wdata[6:0];
        pgos_pkg::CFG_ONESHOT: one_shot_nxt = cfg_wdata[0];
        pgos_pkg::CFG_RETRIG:  retrig_nxt   = cfg_wdata[0];
        pgos_pkg::CFG_AUTO:    auto_nxt     = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // product taken from the new values so it registers together with the written value
  always_comb begin
    peff_nxt = (period_nxt == 16'd0) ? pgos_pkg::PERIOD_DEFAULT : period_nxt;
    dcl_nxt  = (duty_nxt > pgos_pkg::FULL_PERCENT) ? pgos_pkg::FULL_PERCENT : duty_nxt;
    prod_nxt = 23'(peff_nxt) * 23'(dcl_nxt);
  end

  // divide by 100 through the reciprocal, then floor the width at one
  always_comb begin
    quot_full  = 49'(prod_r) * 49'(pgos_pkg::RECIP_100);
    high_w_nxt = quot_full[pgos_pkg::RECIP_SHIFT +: 16];
    if (high_w_nxt == 16'd0) begin
      high_w_nxt = 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    period_r   <= period_nxt;
    duty_r     <= duty_nxt;
    one_shot_r <= one_shot_nxt;
    retrig_r   <= retrig_nxt;
    auto_r     <= auto_nxt;
    prod_r     <= prod_nxt;
    peff_r     <= peff_nxt;
    high_w_r   <= high_w_nxt;
  end

  always_comb begin
    cfg_set.period        = peff_r;
    cfg_set.high_w        = high_w_r;
    cfg_set.one_shot      = one_shot_r;
    cfg_set.retriggerable = retrig_r;
    cfg_set.auto_start    = auto_r;
  end

endmodule

`default_nettype wire

// ----- hdl/pgos_core.sv -----
// pulse state: enable, run, line level and phase counter
`default_nettype none

module pgos_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  pgos_pkg::in_item_t       item,
  input  pgos_pkg::cfg_set_t       cfg_set,
  output pgos_pkg::out_item_t      result_nxt
);

  localparam logic [32:0] CNT_MAX_EXT = (33'd1 << COUNT_WIDTH) - 33'd1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  logic                   en_r, en_nxt;
  logic                   run_r, run_nxt;
  logic                   high_r, high_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;

  logic [15:0]            low_w;
  logic [COUNT_WIDTH-1:0] high_sat;
  logic [COUNT_WIDTH-1:0] low_sat;
  logic                   start_req;

  always_comb begin
    low_w = cfg_set.period - cfg_set.high_w;
    if (low_w == 16'd0) begin
      low_w = 16'd1;
    end
    high_sat = (33'(cfg_set.high_w) > CNT_MAX_EXT) ? '1 : COUNT_WIDTH'(cfg_set.high_w);
    low_sat  = (33'(low_w) > CNT_MAX_EXT) ? '1 : COUNT_WIDTH'(low_w);
  end

  always_comb begin
    en_nxt    = en_r;
    run_nxt   = run_r;
    high_nxt  = high_r;
    rem_nxt   = rem_r;
    start_req = 1'b0;
    unique case (item.operation)
      pgos_pkg::OP_TICK: begin
        if (run_r && en_r) begin
          if (rem_r > CNT_ONE) begin
            rem_nxt = rem_r - CNT_ONE;
          end else if (high_r) begin
            high_nxt = 1'b0;
            if (cfg_set.one_shot) begin
              run_nxt = 1'b0;
              rem_nxt = '0;
            end else begin
              rem_nxt = low_sat;
            end
          end else begin
            high_nxt = 1'b1;
            rem_nxt  = high_sat;
          end
        end
      end
      pgos_pkg::OP_START: begin
        start_req = 1'b1;
      end
      pgos_pkg::OP_STOP: begin
        high_nxt = 1'b0;
        run_nxt  = 1'b0;
        rem_nxt  = '0;
      end
      pgos_pkg::OP_ENABLE: begin
        en_nxt = item.enable_value;
        if (!item.enable_value) begin
          high_nxt = 1'b0;
          run_nxt  = 1'b0;
          rem_nxt  = '0;
        end else begin
          start_req = cfg_set.auto_start;
        end
      end
      pgos_pkg::OP_ACTIVATE: begin
        high_nxt  = 1'b0;
        run_nxt   = 1'b0;
        rem_nxt   = '0;
        start_req = en_r && cfg_set.auto_start;
      end
      default: ;
    endcase
    // a start only takes effect when enabled and not blocked by a live run
    if (start_req && en_nxt && (!run_nxt || cfg_set.retriggerable)) begin
      run_nxt  = 1'b1;
      high_nxt = 1'b1;
      rem_nxt  = high_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b1;
      run_r  <= 1'b0;
      high_r <= 1'b0;
      rem_r  <= '0;
    end else if (fire) begin
      en_r   <= en_nxt;
      run_r  <= run_nxt;
      high_r <= high_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_comb begin
    result_nxt.out_level    = high_nxt;
    result_nxt.out_inverted = ~high_nxt;
    result_nxt.active       = run_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/pulse_generator_one_shot_retrigger.sv -----
// top level: input stage, result stage, config registers and the pulse core
//
//  channel | signals                          | transaction when
//  --------+----------------------------------+----------------------------
//  in      | in_valid, in_ready, in_data      | in_valid & in_ready
//  out     | out_valid, out_ready, out_data   | out_valid & out_ready
//  cfg     | cfg_we, cfg_index, cfg_wdata     | cfg_we
//
// one item per clock while the result is not stalled; an accepted item is registered in
// the input stage, and the core update then loads the result register from it.
// a config write reaches the width logic through a multiply by the duty and
// a reciprocal multiply for the divide by 100; the width register follows the product
// register, so transactions accepted from the next edge after the write see them.
// reset is synchronous and needs no clearing pass; a stalled result holds
// both stages, while an empty input stage keeps taking items.
`default_nettype none

module pulse_generator_one_shot_retrigger #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  pgos_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output pgos_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [pgos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pgos_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  pgos_pkg::in_item_t  in_r;
  logic                in_valid_r;
  pgos_pkg::out_item_t out_r;
  logic                out_valid_r;
  pgos_pkg::out_item_t result_nxt;
  pgos_pkg::cfg_set_t  cfg_set;
  logic                advance;
  logic                fire;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;
  assign fire     = in_valid_r && advance;

  pgos_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_set   (cfg_set)
  );

  pgos_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item       (in_r),
    .cfg_set    (cfg_set),
    .result_nxt (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
